/* src/eca_pkg.sv */
// Shared constants for the elementary cellular automaton block.
package eca_pkg;

    // Default geometry
    localparam int CELLS_DEF        = 1024;
    localparam int HISTORY_ROWS_DEF = 512;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int AGE_W   = 9;
    localparam int WIDX_W  = 4;
    localparam int WORD_W  = 64;
    localparam int RULE_W  = 8;

    // Rule register value after reset
    localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;

    // Command codes carried in kind
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

endpackage

/* src/elementary_cellular_automaton_top.sv */
// A tick reads the last and first cell words, then sweeps the cell memory one word per cycle
// and returns a zero word; a read passes through S_RD, a mark through S_MARK and a restart
// goes straight to S_DONE. One command is in flight at a time; the next is taken the cycle
// after its word enters the output register. Reset is asynchronous: cells return to the
// centre seed at once through per-word valid bits, and the history is emptied by its fill
// count, so no clearing pass is needed.
module elementary_cellular_automaton_top #(
    parameter int CELLS        = eca_pkg::CELLS_DEF,
    parameter int HISTORY_ROWS = eca_pkg::HISTORY_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [eca_pkg::RULE_W-1:0]    cfg_wr_data,
    // command channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [eca_pkg::KIND_W-1:0]    kind,
    input  logic [eca_pkg::AGE_W-1:0]     row_age,
    input  logic [eca_pkg::WIDX_W-1:0]    word_index,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [eca_pkg::WORD_W-1:0]    read_word,
    output logic                          row_valid
);
    import eca_pkg::*;

    localparam int WORDS    = (CELLS + 63) / 64;
    localparam int WA       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST     = WORDS - 1;
    localparam int LASTBITS = CELLS - 64 * (WORDS - 1);
    localparam int CTR      = CELLS / 2;
    localparam int CW       = CTR / 64;
    localparam int CB       = CTR % 64;
    localparam int RW       = $clog2(HISTORY_ROWS);
    localparam int RFW      = $clog2(HISTORY_ROWS + 1);
    localparam int HDEPTH   = HISTORY_ROWS * WORDS;
    localparam int HAW      = $clog2(HDEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TK_LAST,
        S_TK_FIRST,
        S_TK_RUN,
        S_MARK,
        S_RD,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [RULE_W-1:0]    rule_reg;
    logic [RW-1:0]        write_row_reg;
    logic [RFW-1:0]       rows_filled_reg;
    logic [WORDS-1:0]     cell_vld_reg;
    logic [WA-1:0]        idx_reg;
    logic [WORD_W-1:0]    cur_reg;
    logic                 left_reg;
    logic                 cell0_reg;
    logic                 hit_reg;
    logic                 word_ok_reg;
    logic [WORD_W-1:0]    res_word_reg;
    logic                 res_valid_reg;
    logic                 out_valid_reg;
    logic [WORD_W-1:0]    read_word_reg;
    logic                 row_valid_reg;

    // cell memory
    logic [WORD_W-1:0]    cell_mem [WORDS];
    logic [WORD_W-1:0]    cell_q_reg;
    logic                 cell_re;
    logic [WA-1:0]        cell_raddr;
    logic                 cell_we;
    logic [WA-1:0]        cell_waddr;
    logic [WORD_W-1:0]    cell_wdata;

    // history memory
    logic [WORD_W-1:0]    hist_mem [HDEPTH];
    logic [WORD_W-1:0]    hist_q_reg;
    logic                 hist_re;
    logic [HAW-1:0]       hist_raddr;
    logic                 hist_we;
    logic [HAW-1:0]       hist_waddr;

    logic                 accept;
    logic                 out_free;
    logic                 is_last;
    logic [WORD_W+1:0]    win;
    logic [WORD_W-1:0]    next_word;
    logic                 age_hit;
    logic                 word_ok;
    logic [RW:0]          slot_sum;
    logic [RW-1:0]        slot;
    logic [WORD_W-1:0]    centre_word;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign read_word = read_word_reg;
    assign row_valid = row_valid_reg;

    assign is_last     = (idx_reg == WA'(LAST));
    assign centre_word = WORD_W'(1) << CB;

    // Compute the new generation of the current word
    always_comb
    begin
        win = {(is_last ? 1'b0 : cell_q_reg[0]), cur_reg, left_reg};
        if (is_last)
        begin
            win[LASTBITS+1] = cell0_reg;
        end
        for (int b = 0; b < WORD_W; b++)
        begin
            next_word[b] = rule_reg[{win[b], win[b+1], win[b+2]}];
            if (is_last && (b >= LASTBITS))
            begin
                next_word[b] = 1'b0;
            end
        end
    end

    // Locate the requested history row
    always_comb
    begin
        age_hit  = (32'(row_age) < 32'(rows_filled_reg));
        word_ok  = (32'(word_index) < WORDS);
        slot_sum = (RW+1)'(write_row_reg) + (RW+1)'(HISTORY_ROWS - 1) - (RW+1)'(row_age);
        if (32'(slot_sum) >= HISTORY_ROWS)
        begin
            slot = RW'(32'(slot_sum) - HISTORY_ROWS);
        end
        else
        begin
            slot = RW'(slot_sum);
        end
        hist_raddr = HAW'(slot) * HAW'(WORDS) + HAW'(word_index);
        hist_re    = accept && (kind == KIND_READ);
    end

    // Drive cell and history memory ports
    always_comb
    begin
        cell_re    = 1'b0;
        cell_raddr = '0;
        cell_we    = 1'b0;
        cell_waddr = idx_reg;
        cell_wdata = next_word;
        hist_we    = 1'b0;
        hist_waddr = HAW'(write_row_reg) * HAW'(WORDS) + HAW'(idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == KIND_TICK))
                begin
                    cell_re    = 1'b1;
                    cell_raddr = WA'(LAST);
                end
                else if (accept && (kind == KIND_MARK))
                begin
                    cell_re    = 1'b1;
                    cell_raddr = WA'(CW);
                end
            end
            S_TK_LAST:
            begin
                cell_re    = 1'b1;
                cell_raddr = '0;
            end
            S_TK_FIRST:
            begin
                cell_re    = (WORDS > 1);
                cell_raddr = WA'(1);
            end
            S_TK_RUN:
            begin
                cell_we    = 1'b1;
                hist_we    = 1'b1;
                cell_re    = (32'(idx_reg) + 2 <= LAST);
                cell_raddr = WA'(32'(idx_reg) + 2);
            end
            S_MARK:
            begin
                cell_we    = 1'b1;
                cell_waddr = WA'(CW);
                cell_wdata = cell_q_reg | centre_word;
            end
            S_RD, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Cell memory: invalid words read as the seeded row
    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re)
        begin
            if (cell_vld_reg[cell_raddr])
            begin
                cell_q_reg <= cell_mem[cell_raddr];
            end
            else if (cell_raddr == WA'(CW))
            begin
                cell_q_reg <= centre_word;
            end
            else
            begin
                cell_q_reg <= '0;
            end
        end
    end

    // History memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= next_word;
        end
        if (hist_re)
        begin
            hist_q_reg <= hist_mem[hist_raddr];
        end
    end

    // Sequencer, state registers and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rule_reg        <= RULE_RESET;
            write_row_reg   <= '0;
            rows_filled_reg <= '0;
            cell_vld_reg    <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            cur_reg         <= '0;
            left_reg        <= 1'b0;
            cell0_reg       <= 1'b0;
            hit_reg         <= 1'b0;
            word_ok_reg     <= 1'b0;
            res_word_reg    <= '0;
            res_valid_reg   <= 1'b0;
            read_word_reg   <= '0;
            row_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rule_reg <= cfg_wr_data;
            end
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_word_reg  <= '0;
                        res_valid_reg <= 1'b0;
                        hit_reg       <= age_hit;
                        word_ok_reg   <= word_ok;
                        unique case (kind)
                            KIND_TICK:
                            begin
                                state_reg <= S_TK_LAST;
                            end
                            KIND_RESTART:
                            begin
                                cell_vld_reg    <= '0;
                                write_row_reg   <= '0;
                                rows_filled_reg <= '0;
                                state_reg       <= S_DONE;
                            end
                            KIND_MARK:
                            begin
                                state_reg <= S_MARK;
                            end
                            KIND_READ:
                            begin
                                state_reg <= S_RD;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_TK_LAST:
                begin
                    left_reg  <= cell_q_reg[LASTBITS-1];
                    state_reg <= S_TK_FIRST;
                end
                S_TK_FIRST:
                begin
                    cur_reg   <= cell_q_reg;
                    cell0_reg <= cell_q_reg[0];
                    idx_reg   <= '0;
                    state_reg <= S_TK_RUN;
                end
                S_TK_RUN:
                begin
                    cell_vld_reg[idx_reg] <= 1'b1;
                    if (is_last)
                    begin
                        if (write_row_reg == RW'(HISTORY_ROWS - 1))
                        begin
                            write_row_reg <= '0;
                        end
                        else
                        begin
                            write_row_reg <= write_row_reg + 1'b1;
                        end
                        if (rows_filled_reg != RFW'(HISTORY_ROWS))
                        begin
                            rows_filled_reg <= rows_filled_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        left_reg <= cur_reg[WORD_W-1];
                        cur_reg  <= cell_q_reg;
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                S_MARK:
                begin
                    cell_vld_reg[CW] <= 1'b1;
                    write_row_reg    <= '0;
                    rows_filled_reg  <= '0;
                    state_reg        <= S_DONE;
                end
                S_RD:
                begin
                    res_valid_reg <= hit_reg;
                    res_word_reg  <= (hit_reg && word_ok_reg) ? hist_q_reg : '0;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    // hand the word over once the output slot is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        read_word_reg <= res_word_reg;
                        row_valid_reg <= res_valid_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
